FILE: design/dimsel_pkg.sv
// ----------------------------------------------------------------------------
// Dimuon event selector package
// Shared types, register and item codes, and limits of the selector.
// ----------------------------------------------------------------------------
package dimsel_pkg;

	// Object counters saturate at the smaller of this and the counter range.
	localparam int MAX_OBJECTS = 63;
	localparam int CNT_W       = 6;
	localparam int COUNT_CAP   = (MAX_OBJECTS < 63) ? MAX_OBJECTS : 63;

	// Azimuth wrap, radians in units of 1/256.
	localparam logic signed [12:0] PHI_HALF_TURN = 13'sd804;
	localparam logic signed [12:0] PHI_FULL_TURN = 13'sd1608;

	// Item kinds.
	localparam logic [1:0] ACT_HEADER = 2'd0;
	localparam logic [1:0] ACT_MUON   = 2'd1;
	localparam logic [1:0] ACT_JET    = 2'd2;

	// Fail reasons, in priority order.
	localparam logic [2:0] FAIL_NONE       = 3'd0;
	localparam logic [2:0] FAIL_MUON_COUNT = 3'd1;
	localparam logic [2:0] FAIL_MET        = 3'd2;
	localparam logic [2:0] FAIL_NON_GLOBAL = 3'd3;
	localparam logic [2:0] FAIL_CHARGE     = 3'd4;
	localparam logic [2:0] FAIL_MUON_PT    = 3'd5;
	localparam logic [2:0] FAIL_BTAG       = 3'd6;
	localparam logic [2:0] FAIL_JET_COUNT  = 3'd7;

	// Register word indexes on the configuration port.
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_MET_MIN        = 3'd0;
	localparam logic [2:0] REG_LEAD_PT_MIN    = 3'd1;
	localparam logic [2:0] REG_SUBLEAD_PT_MIN = 3'd2;
	localparam logic [2:0] REG_BTAG_MAX       = 3'd3;
	localparam logic [2:0] REG_DR_SQUARED_MIN = 3'd4;
	localparam logic [2:0] REG_MAX_CLEAN_JETS = 3'd5;

	localparam logic [15:0] MET_MIN_RST        = 16'd440;
	localparam logic [15:0] LEAD_PT_MIN_RST    = 16'd200;
	localparam logic [15:0] SUBLEAD_PT_MIN_RST = 16'd160;
	localparam logic [10:0] BTAG_MAX_RST       = 11'd599;
	localparam logic [23:0] DR_SQUARED_MIN_RST = 24'd10486;
	localparam logic [5:0]  MAX_CLEAN_JETS_RST = 6'd1;

	typedef struct packed {
		logic [15:0] met_min;
		logic [15:0] lead_pt_min;
		logic [15:0] sublead_pt_min;
		logic [10:0] btag_max;
		logic [23:0] dr_squared_min;
		logic [5:0]  max_clean_jets;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] momentum;
		logic [11:0] eta;
		logic [10:0] phi;
		logic [1:0]  charge;
		logic        is_global;
		logic [10:0] btag;
		logic        last;
	} item_t;

	typedef struct packed {
		logic [15:0]       met_value;
		logic [CNT_W-1:0]  muon_count;
		logic [6:0]        charge_sum;
		logic              all_global;
		logic [1:0][15:0]  muon_pt;
		logic [1:0][11:0]  mu_eta;
		logic [1:0][10:0]  mu_phi;
		logic              btag_veto;
		logic [CNT_W-1:0]  jet_count;
	} evt_t;

	typedef struct packed {
		logic       pass;
		logic [2:0] fail_reason;
		logic [5:0] clean_jets;
	} result_t;

	function automatic evt_t clear_evt();
		evt_t e;
		e = '0;
		e.all_global = 1'b1;
		return e;
	endfunction

endpackage

FILE: design/dimsel_cfg_regs.sv
// ----------------------------------------------------------------------------
// Dimuon selector configuration registers
// APB-style register file holding the cut thresholds.
// ----------------------------------------------------------------------------
module dimsel_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dimsel_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output dimsel_pkg::cfg_t              cfg
);

	dimsel_pkg::cfg_t cfg_q;
	logic             wr_en;
	logic [2:0]       widx;

	assign wr_en = psel && penable && pwrite;
	assign widx  = paddr[4:2];
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.met_min        <= dimsel_pkg::MET_MIN_RST;
			cfg_q.lead_pt_min    <= dimsel_pkg::LEAD_PT_MIN_RST;
			cfg_q.sublead_pt_min <= dimsel_pkg::SUBLEAD_PT_MIN_RST;
			cfg_q.btag_max       <= dimsel_pkg::BTAG_MAX_RST;
			cfg_q.dr_squared_min <= dimsel_pkg::DR_SQUARED_MIN_RST;
			cfg_q.max_clean_jets <= dimsel_pkg::MAX_CLEAN_JETS_RST;
		end else if (wr_en) begin
			case (widx)
				dimsel_pkg::REG_MET_MIN:        cfg_q.met_min        <= pwdata[15:0];
				dimsel_pkg::REG_LEAD_PT_MIN:    cfg_q.lead_pt_min    <= pwdata[15:0];
				dimsel_pkg::REG_SUBLEAD_PT_MIN: cfg_q.sublead_pt_min <= pwdata[15:0];
				dimsel_pkg::REG_BTAG_MAX:       cfg_q.btag_max       <= pwdata[10:0];
				dimsel_pkg::REG_DR_SQUARED_MIN: cfg_q.dr_squared_min <= pwdata[23:0];
				dimsel_pkg::REG_MAX_CLEAN_JETS: cfg_q.max_clean_jets <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			dimsel_pkg::REG_MET_MIN:        prdata = {16'd0, cfg_q.met_min};
			dimsel_pkg::REG_LEAD_PT_MIN:    prdata = {16'd0, cfg_q.lead_pt_min};
			dimsel_pkg::REG_SUBLEAD_PT_MIN: prdata = {16'd0, cfg_q.sublead_pt_min};
			dimsel_pkg::REG_BTAG_MAX:       prdata = {21'd0, cfg_q.btag_max};
			dimsel_pkg::REG_DR_SQUARED_MIN: prdata = {8'd0, cfg_q.dr_squared_min};
			dimsel_pkg::REG_MAX_CLEAN_JETS: prdata = {26'd0, cfg_q.max_clean_jets};
			default:                        prdata = 32'd0;
		endcase
	end

endmodule

FILE: design/dimsel_dist.sv
// ----------------------------------------------------------------------------
// Dimuon selector jet-muon proximity check
// Squared angular distance between a jet and one stored muon, with the
// azimuth difference wrapped once, compared against the removal threshold.
// ----------------------------------------------------------------------------
module dimsel_dist (
	input  logic [11:0] mu_eta,
	input  logic [10:0] mu_phi,
	input  logic [11:0] jet_eta,
	input  logic [10:0] jet_phi,
	input  logic [23:0] dr_squared_min,
	output logic        near
);

	logic signed [12:0] deta;
	logic signed [12:0] dphi_raw;
	logic signed [12:0] dphi;
	logic signed [25:0] deta_sq;
	logic signed [25:0] dphi_sq;
	logic [24:0]        dist_sq;

	assign deta     = $signed({mu_eta[11], mu_eta}) - $signed({jet_eta[11], jet_eta});
	assign dphi_raw = $signed({{2{mu_phi[10]}}, mu_phi}) - $signed({{2{jet_phi[10]}}, jet_phi});

	always_comb begin
		if (dphi_raw > dimsel_pkg::PHI_HALF_TURN) begin
			dphi = dphi_raw - dimsel_pkg::PHI_FULL_TURN;
		end else if (dphi_raw < -dimsel_pkg::PHI_HALF_TURN) begin
			dphi = dphi_raw + dimsel_pkg::PHI_FULL_TURN;
		end else begin
			dphi = dphi_raw;
		end
	end

	// The eta term stays below 2^24 and the wrapped phi term below 2^20.
	assign deta_sq = deta * deta;
	assign dphi_sq = dphi * dphi;
	assign dist_sq = {1'b0, deta_sq[23:0]} + {5'd0, dphi_sq[19:0]};
	assign near    = dist_sq < {1'b0, dr_squared_min};

endmodule

FILE: design/dimsel_accum.sv
// ----------------------------------------------------------------------------
// Dimuon selector event accumulator
// Holds the per-event state, folds in one item per step and forms the
// verdict from the updated state when the item closes the event.
// ----------------------------------------------------------------------------
module dimsel_accum (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  dimsel_pkg::item_t   item,
	input  dimsel_pkg::cfg_t    cfg,
	output dimsel_pkg::result_t res
);

	dimsel_pkg::evt_t evt_q;
	dimsel_pkg::evt_t nxt;
	logic [1:0]       near;
	logic             drop;
	logic signed [7:0] chg_sum;
	logic [15:0]      pt_hi;
	logic [15:0]      pt_lo;
	logic [dimsel_pkg::CNT_W-1:0] cap;

	assign cap = dimsel_pkg::CNT_W'(dimsel_pkg::COUNT_CAP);

	dimsel_dist u_dist0 (
		.mu_eta         (evt_q.mu_eta[0]),
		.mu_phi         (evt_q.mu_phi[0]),
		.jet_eta        (item.eta),
		.jet_phi        (item.phi),
		.dr_squared_min (cfg.dr_squared_min),
		.near           (near[0])
	);

	dimsel_dist u_dist1 (
		.mu_eta         (evt_q.mu_eta[1]),
		.mu_phi         (evt_q.mu_phi[1]),
		.jet_eta        (item.eta),
		.jet_phi        (item.phi),
		.dr_squared_min (cfg.dr_squared_min),
		.near           (near[1])
	);

	assign chg_sum = $signed({evt_q.charge_sum[6], evt_q.charge_sum})
		+ $signed({{6{item.charge[1]}}, item.charge});

	// Only muons already stored take part in jet removal.
	assign drop = (near[0] && (evt_q.muon_count >= 6'd1))
		|| (near[1] && (evt_q.muon_count >= 6'd2));

	always_comb begin
		nxt = evt_q;
		case (item.action)
			dimsel_pkg::ACT_HEADER: begin
				nxt = dimsel_pkg::clear_evt();
				nxt.met_value = item.momentum;
			end
			dimsel_pkg::ACT_MUON: begin
				if (evt_q.muon_count < 6'd2) begin
					nxt.muon_pt[evt_q.muon_count[0]] = item.momentum;
					nxt.mu_eta[evt_q.muon_count[0]]  = item.eta;
					nxt.mu_phi[evt_q.muon_count[0]]  = item.phi;
				end
				if (evt_q.muon_count < cap) begin
					nxt.muon_count = evt_q.muon_count + 6'd1;
				end
				if (chg_sum > 8'sd63) begin
					nxt.charge_sum = 7'h3F;
				end else if (chg_sum < -8'sd64) begin
					nxt.charge_sum = 7'h40;
				end else begin
					nxt.charge_sum = chg_sum[6:0];
				end
				if (!item.is_global) begin
					nxt.all_global = 1'b0;
				end
			end
			dimsel_pkg::ACT_JET: begin
				if (item.btag > cfg.btag_max) begin
					nxt.btag_veto = 1'b1;
				end
				if (!drop && (evt_q.jet_count < cap)) begin
					nxt.jet_count = evt_q.jet_count + 6'd1;
				end
			end
			default: ;
		endcase
	end

	assign pt_hi = (nxt.muon_pt[0] > nxt.muon_pt[1]) ? nxt.muon_pt[0] : nxt.muon_pt[1];
	assign pt_lo = (nxt.muon_pt[0] > nxt.muon_pt[1]) ? nxt.muon_pt[1] : nxt.muon_pt[0];

	always_comb begin
		if (nxt.muon_count != 6'd2) begin
			res.fail_reason = dimsel_pkg::FAIL_MUON_COUNT;
		end else if (!(nxt.met_value > cfg.met_min)) begin
			res.fail_reason = dimsel_pkg::FAIL_MET;
		end else if (!nxt.all_global) begin
			res.fail_reason = dimsel_pkg::FAIL_NON_GLOBAL;
		end else if (nxt.charge_sum != 7'd0) begin
			res.fail_reason = dimsel_pkg::FAIL_CHARGE;
		end else if (!(pt_hi > cfg.lead_pt_min && pt_lo > cfg.sublead_pt_min)) begin
			res.fail_reason = dimsel_pkg::FAIL_MUON_PT;
		end else if (nxt.btag_veto) begin
			res.fail_reason = dimsel_pkg::FAIL_BTAG;
		end else if (nxt.jet_count > cfg.max_clean_jets) begin
			res.fail_reason = dimsel_pkg::FAIL_JET_COUNT;
		end else begin
			res.fail_reason = dimsel_pkg::FAIL_NONE;
		end
		res.pass       = (res.fail_reason == dimsel_pkg::FAIL_NONE);
		res.clean_jets = nxt.jet_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_q <= dimsel_pkg::clear_evt();
		end else if (step) begin
			// An event that has just been judged starts over from the cleared state.
			evt_q <= item.last ? dimsel_pkg::clear_evt() : nxt;
		end
	end

endmodule

FILE: design/dimuon_event_selector_core.sv
// ----------------------------------------------------------------------------
// Dimuon event selector
// Streaming event filter: a header with missing energy, then muons, then
// jets; one verdict per event on the item flagged last.
// ----------------------------------------------------------------------------
// Input items transfer on in_valid while in_stall is low; verdicts leave on
// out_valid and are taken while out_stall is low. Thresholds are written
// through the APB-style port, and the user must keep that between events
// only; the block itself does not enforce it. Each item is captured in an
// input register and from there folded into the event state, so one item
// is taken every cycle while the input is not stalled. Once the output
// register is free, the verdict is loaded into it as the last item of its
// event leaves the input register; the receiver takes it from there.
// Items that close no event never wait on the output. A closing item waits
// in the input register while an earlier verdict is still stalled, and the
// input stalls behind it until that verdict transfers.
// Reset clears the pipeline and the event state and restores the default
// thresholds.
// ----------------------------------------------------------------------------
module dimuon_event_selector_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dimsel_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// item input
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    action,
	input  logic [15:0]                   momentum,
	input  logic signed [11:0]            eta,
	input  logic signed [10:0]            phi,
	input  logic signed [1:0]             charge,
	input  logic                          is_global,
	input  logic [10:0]                   btag,
	input  logic                          last,
	// verdict output
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          pass,
	output logic [2:0]                    fail_reason,
	output logic [5:0]                    clean_jets
);

	dimsel_pkg::cfg_t    cfg;
	dimsel_pkg::item_t   item_s1;
	logic                valid_s1;
	dimsel_pkg::result_t res;
	dimsel_pkg::result_t res_q;
	logic                out_valid_q;
	logic                out_free;
	logic                adv_s1;
	logic                in_take;

	assign pready = 1'b1;

	dimsel_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && (!item_s1.last || out_free);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.action    <= action;
			item_s1.momentum  <= momentum;
			item_s1.eta       <= eta;
			item_s1.phi       <= phi;
			item_s1.charge    <= charge;
			item_s1.is_global <= is_global;
			item_s1.btag      <= btag;
			item_s1.last      <= last;
		end
	end

	dimsel_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && item_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_s1.last) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign pass        = res_q.pass;
	assign fail_reason = res_q.fail_reason;
	assign clean_jets  = res_q.clean_jets;

endmodule

FILE: design/dimsel_checker.sv
// ----------------------------------------------------------------------------
// Dimuon selector port checker
// Port-level assertions on the verdict channel and input flow control.
// ----------------------------------------------------------------------------
module dimsel_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       pass,
	input logic [2:0] fail_reason,
	input logic [5:0] clean_jets
);

	// A verdict held by the receiver stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("verdict dropped while stalled");

	// The pass flag agrees with the fail reason.
	a_pass_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pass == (fail_reason == dimsel_pkg::FAIL_NONE)))
		else $error("pass flag disagrees with fail reason");

	// Too many clean jets can only be reported with at least one jet kept.
	a_jet_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (fail_reason == dimsel_pkg::FAIL_JET_COUNT) |-> (clean_jets != 6'd0))
		else $error("jet count failure with no clean jets");

	// The input only waits behind a verdict that the receiver holds off.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held verdict");

	// Nothing is offered right after reset.
	a_reset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !out_valid)
		else $error("verdict offered right after reset");

endmodule

bind dimuon_event_selector_core dimsel_checker u_dimsel_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.pass        (pass),
	.fail_reason (fail_reason),
	.clean_jets  (clean_jets)
);
